/* rtl/tcpacc_pkg.sv */
package tcpacc_pkg;

    localparam logic [15:0] MSS_RESET  = 16'd1460;
    localparam logic [7:0]  DUP_LIMIT  = 8'd3;
    localparam logic [7:0]  DUP_MAX    = 8'd255;
    localparam logic [15:0] CWND_MAX   = 16'hFFFF;

    localparam int          DIV_CNT_W  = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LONG  = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DIV_SHORT = 6'd16;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 112;

    typedef enum logic [1:0] {
        PH_OPEN     = 2'd0,
        PH_DISORDER = 2'd1,
        PH_RECOVERY = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_FLIGHT,
        ST_DIV_WIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic ready;
        logic div_step;
        logic load_out;
    } t_ctrl;

    // a is after b, modulo 2^32
    function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

/* rtl/tcp_ack_congestion_control_top.sv */
// TCP sender congestion control (Reno fast retransmit / fast recovery).
// Input stream: one request per received ACK or connection open.
//   s_axis_tuser carries func (1 = open, 0 = ACK); s_axis_tdata carries
//   ack_number, advertised_window and send_next.
// Output stream: exactly one result per request, in order, holding the
//   congestion state after the request and the send window figures.
// Configuration: i_cfg_we / i_cfg_wdata write max_segment (0 acts as 1);
//   write only while no request is in flight.
// Sequencing: an in-range ACK goes from the accepting edge through a
//   multiply state, then a shared bit-serial restoring divider runs
//   32 steps and a handover for the in-flight segment count and
//   16 steps and a capture for the send window in segments, then the
//   result is loaded into the output register. Opens and out-of-range ACKs
//   skip the divider and go straight to the output-load state.
// Flow control: one request at a time; s_axis_tready is high only while idle,
//   so the next request is taken only after the previous result has been
//   loaded into the output register.
// Reset (synchronous, active low) restores cwnd 1, phase open, dup count,
//   ssthresh, peer window and sequence state zero and max_segment 1460.
// When the receiver stalls, the result holds in the output register; the
//   next request is still taken and its result waits until the slot frees.
module tcp_ack_congestion_control_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [15:0]                     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] ack_number, [47:32] advertised_window, [79:48] send_next
    input  logic [tcpacc_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] func
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] retransmit, [16:1] cong_window, [32:17] slow_start_threshold,
    // [34:33] cong_phase, [42:35] dup_count, [58:43] send_window,
    // [75:59] allow_send, [107:76] unacked_base, [111:108] zero
    output logic [tcpacc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    tcpacc_pkg::t_state r_state, n_state;
    tcpacc_pkg::t_ctrl  w_ctrl;

    logic [15:0] r_mss;
    logic [31:0] r_una, n_una;
    logic [15:0] r_peer;
    logic [15:0] r_cwnd, n_cwnd;
    logic [15:0] r_ssth, n_ssth;
    logic [7:0]  r_dup, n_dup;
    tcpacc_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_mark, n_mark;
    logic        r_parity, n_parity;
    logic        n_retx, n_inrange;

    logic        r_retx;
    logic        r_inrange;
    logic [31:0] r_diff;
    logic [15:0] r_swnd;
    logic [31:0] r_flight;
    logic signed [16:0] r_allow;

    logic [15:0] r_div_rem;
    logic [31:0] r_div_quo;
    logic [tcpacc_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic        r_m_valid;
    logic [tcpacc_pkg::M_DATA_W-1:0] r_m_data;

    logic        w_accept;
    logic        w_func;
    logic [31:0] w_ack, w_snext;
    logic [15:0] w_adv;
    logic [15:0] w_mss;

    logic        w_after, w_eq;
    logic [15:0] w_cw1;
    logic [7:0]  w_dup_inc;
    logic [31:0] w_una1;

    logic [31:0] w_prod;
    logic [16:0] w_trial;
    logic        w_fit;
    logic [15:0] w_rem_next;
    logic [31:0] w_flight;
    logic signed [33:0] w_allow_full;
    logic signed [16:0] w_allow;

    assign w_func   = s_axis_tuser;
    assign w_ack    = s_axis_tdata[31:0];
    assign w_adv    = s_axis_tdata[47:32];
    assign w_snext  = s_axis_tdata[79:48];
    assign w_mss    = (r_mss == 16'd0) ? 16'd1 : r_mss;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = w_ctrl.ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Congestion state update for one request
    always_comb begin
        n_una     = r_una;
        n_cwnd    = r_cwnd;
        n_ssth    = r_ssth;
        n_dup     = r_dup;
        n_phase   = r_phase;
        n_mark    = r_mark;
        n_parity  = r_parity;
        n_retx    = 1'b0;
        n_inrange = 1'b0;
        w_after   = tcpacc_pkg::seq_after(w_ack, r_una);
        w_eq      = (w_ack == r_una);
        w_dup_inc = (r_dup < tcpacc_pkg::DUP_MAX) ? r_dup + 8'd1 : r_dup;
        w_cw1     = r_cwnd;
        w_una1    = r_una;
        if (w_func) begin
            n_cwnd  = 16'd1;
            n_phase = tcpacc_pkg::PH_OPEN;
            n_una   = w_ack;
        end else begin
            if (w_after) begin
                if (r_ssth == 16'd0 || r_cwnd < r_ssth) begin
                    if (r_cwnd < tcpacc_pkg::CWND_MAX) w_cw1 = r_cwnd + 16'd1;
                end else begin
                    n_parity = !r_parity;
                    if (r_parity && r_cwnd < tcpacc_pkg::CWND_MAX) w_cw1 = r_cwnd + 16'd1;
                end
            end
            n_cwnd = w_cw1;
            unique case (r_phase)
                tcpacc_pkg::PH_OPEN: begin
                    if (w_eq) begin
                        n_dup   = 8'd1;
                        n_phase = tcpacc_pkg::PH_DISORDER;
                    end
                end
                tcpacc_pkg::PH_DISORDER: begin
                    if (w_ack == w_snext) begin
                        n_dup   = 8'd0;
                        n_phase = tcpacc_pkg::PH_OPEN;
                    end else if (w_eq) begin
                        n_dup = w_dup_inc;
                        if (w_dup_inc >= tcpacc_pkg::DUP_LIMIT) begin
                            n_retx  = 1'b1;
                            n_cwnd  = {1'b0, w_cw1[15:1]};
                            n_ssth  = {2'b0, w_cw1[15:2]};
                            n_phase = tcpacc_pkg::PH_RECOVERY;
                            n_mark  = w_snext;
                        end
                    end
                end
                tcpacc_pkg::PH_RECOVERY: begin
                    if (!tcpacc_pkg::seq_after(r_mark, w_ack)) begin
                        n_dup   = 8'd0;
                        n_phase = tcpacc_pkg::PH_OPEN;
                    end else if (w_after) begin
                        n_dup  = 8'd0;
                        w_una1 = w_ack;
                        n_retx = 1'b1;
                    end else if (w_eq) begin
                        n_dup = w_dup_inc;
                    end
                end
                default: begin
                end
            endcase
            n_una     = w_una1;
            n_inrange = !tcpacc_pkg::seq_after(w_una1, w_ack)
                        && !tcpacc_pkg::seq_after(w_ack, w_snext);
            if (n_inrange) n_una = w_ack;
        end
    end

    // Shared divider step and window arithmetic
    always_comb begin
        w_prod     = r_cwnd * w_mss;
        w_trial    = {r_div_rem, r_div_quo[31]};
        w_fit      = (w_trial >= {1'b0, w_mss});
        w_rem_next = w_fit ? 16'(w_trial - {1'b0, w_mss}) : w_trial[15:0];
        w_flight   = (r_div_quo <= {24'd0, r_dup}) ? 32'd0 : r_div_quo - {24'd0, r_dup};
        w_allow_full = $signed({18'd0, r_div_quo[15:0]}) - $signed({2'd0, r_flight});
        w_allow    = (w_allow_full < -34'sd65536) ? -17'sd65536 : w_allow_full[16:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcpacc_pkg::ST_IDLE: begin
                if (w_accept) n_state = n_inrange ? tcpacc_pkg::ST_MUL : tcpacc_pkg::ST_DONE;
            end
            tcpacc_pkg::ST_MUL:        n_state = tcpacc_pkg::ST_DIV_FLIGHT;
            tcpacc_pkg::ST_DIV_FLIGHT: begin
                if (r_div_cnt == '0) n_state = tcpacc_pkg::ST_DIV_WIN;
            end
            tcpacc_pkg::ST_DIV_WIN: begin
                if (r_div_cnt == '0) n_state = tcpacc_pkg::ST_DONE;
            end
            tcpacc_pkg::ST_DONE: begin
                if (!r_m_valid || m_axis_tready) n_state = tcpacc_pkg::ST_IDLE;
            end
            default: n_state = tcpacc_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        w_ctrl = '0;
        unique case (r_state)
            tcpacc_pkg::ST_IDLE:       w_ctrl.ready    = 1'b1;
            tcpacc_pkg::ST_MUL:        w_ctrl.div_step = 1'b0;
            tcpacc_pkg::ST_DIV_FLIGHT: w_ctrl.div_step = (r_div_cnt != '0);
            tcpacc_pkg::ST_DIV_WIN:    w_ctrl.div_step = (r_div_cnt != '0);
            tcpacc_pkg::ST_DONE:       w_ctrl.load_out = !r_m_valid || m_axis_tready;
            default:                   w_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tcpacc_pkg::ST_IDLE;
            r_mss     <= tcpacc_pkg::MSS_RESET;
            r_una     <= 32'd0;
            r_peer    <= 16'd0;
            r_cwnd    <= 16'd1;
            r_ssth    <= 16'd0;
            r_dup     <= 8'd0;
            r_phase   <= tcpacc_pkg::PH_OPEN;
            r_mark    <= 32'd0;
            r_parity  <= 1'b0;
            r_m_valid <= 1'b0;
            r_inrange <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mss <= i_cfg_wdata;
            if (w_accept) begin
                r_una     <= n_una;
                r_cwnd    <= n_cwnd;
                r_ssth    <= n_ssth;
                r_dup     <= n_dup;
                r_phase   <= n_phase;
                r_mark    <= n_mark;
                r_parity  <= n_parity;
                r_inrange <= n_inrange;
                if (n_inrange) r_peer <= w_adv;
            end
            if (w_ctrl.load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_retx <= n_retx;
            r_diff <= w_snext - w_ack;
        end
        if (r_state == tcpacc_pkg::ST_MUL) begin
            r_swnd    <= (w_prod < {16'd0, r_peer}) ? w_prod[15:0] : r_peer;
            r_div_rem <= 16'd0;
            r_div_quo <= r_diff;
            r_div_cnt <= tcpacc_pkg::DIV_LONG;
        end
        if (w_ctrl.div_step) begin
            r_div_rem <= w_rem_next;
            r_div_quo <= {r_div_quo[30:0], w_fit};
            r_div_cnt <= r_div_cnt - 6'd1;
        end
        // hand the divider over to the window division
        if (r_state == tcpacc_pkg::ST_DIV_FLIGHT && r_div_cnt == '0) begin
            r_flight  <= w_flight;
            r_div_rem <= 16'd0;
            r_div_quo <= {r_swnd, 16'd0};
            r_div_cnt <= tcpacc_pkg::DIV_SHORT;
        end
        if (r_state == tcpacc_pkg::ST_DIV_WIN && r_div_cnt == '0) begin
            r_allow <= w_allow;
        end
        if (w_ctrl.load_out) begin
            r_m_data <= {4'd0, r_una,
                         r_inrange ? r_allow : 17'sd0,
                         r_inrange ? r_swnd : 16'd0,
                         r_dup, r_phase, r_ssth, r_cwnd, r_retx};
        end
    end

endmodule
